>>> rtl/ftn_pkg.sv
// Package for the focus tab-order navigator: command codes, FSM states,
// and the structs passed between controller, datapath and top level.
// No dependencies.
`default_nettype none

package ftn_pkg;

    typedef enum logic [1:0] {
        MODE_CLEAR  = 2'd0,
        MODE_ADD    = 2'd1,
        MODE_SELECT = 2'd2,
        MODE_KEY    = 2'd3
    } ftn_mode_t;

    typedef enum logic [1:0] {
        PRESS_UP    = 2'd0,
        PRESS_DOWN  = 2'd1,
        PRESS_OK    = 2'd2,
        PRESS_OTHER = 2'd3
    } ftn_press_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_COMMIT,
        ST_RESULT
    } ftn_state_t;

    // Tab index of an element that cannot take focus (-1 as 8 bits)
    localparam logic [7:0] TAB_NONE = 8'hFF;
    // Search origin when nothing is hovered: below all (up), above all (down)
    localparam logic signed [8:0] PREV_UP_NONE   = -9'sd1;
    localparam logic signed [8:0] PREV_DOWN_NONE = 9'sd255;
    // Nearest-distance start value; a distance of this size never wins
    localparam logic [7:0] DIFF_NONE = 8'hFF;

    typedef struct packed {
        ftn_mode_t   mode;
        logic [7:0]  elem_tab;
        ftn_press_t  press_kind;
        logic        toggle_flag;
        logic        select_value;
    } ftn_item_t;

    typedef struct packed {
        logic        hover_valid;
        logic [3:0]  hover_slot;
        logic        dispatch;
        logic        selected;
        logic        add_rejected;
    } ftn_result_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic scan_step;
        logic commit;
        logic load_out;
    } ftn_cmd_t;

    typedef struct packed {
        logic move_req;
        logic scan_done;
    } ftn_status_t;

endpackage

`default_nettype wire

>>> rtl/ftn_ifs.sv
// Valid/ready channel interfaces for command words and result words.
// Depends on nothing; payload fields are plain logic.
`default_nettype none

interface ftn_req_if;
    logic              valid;
    logic              ready;
    logic [1:0]        mode;
    logic signed [7:0] elem_tab;
    logic [1:0]        press_kind;
    logic              toggle_flag;
    logic              select_value;

    modport source (output valid, mode, elem_tab, press_kind, toggle_flag, select_value,
                    input ready);
    modport sink   (input valid, mode, elem_tab, press_kind, toggle_flag, select_value,
                    output ready);
endinterface

interface ftn_rsp_if;
    logic       valid;
    logic       ready;
    logic       hover_valid;
    logic [3:0] hover_slot;
    logic       dispatch;
    logic       selected;
    logic       add_rejected;

    modport source (output valid, hover_valid, hover_slot, dispatch, selected, add_rejected,
                    input ready);
    modport sink   (input valid, hover_valid, hover_slot, dispatch, selected, add_rejected,
                    output ready);
endinterface

`default_nettype wire

>>> rtl/ftn_ctrl.sv
// Controller FSM of the focus tab-order navigator: sequences capture,
// execution, table scan, commit and result hand-off. Uses ftn_pkg.
`default_nettype none

module ftn_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  ftn_pkg::ftn_status_t st,
    output ftn_pkg::ftn_cmd_t    cmd
);
    import ftn_pkg::*;

    ftn_state_t state_reg;
    ftn_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (in_valid) state_next = ST_EXEC;
            ST_EXEC:   state_next = st.move_req ? ST_SCAN : ST_RESULT;
            ST_SCAN:   if (st.scan_done) state_next = ST_COMMIT;
            ST_COMMIT: state_next = ST_RESULT;
            ST_RESULT: if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        in_ready  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            ST_EXEC:   cmd.exec = 1'b1;
            ST_SCAN:   cmd.scan_step = 1'b1;
            ST_COMMIT: cmd.commit = 1'b1;
            ST_RESULT: cmd.load_out = out_free;
            default:   cmd = '0;
        endcase
    end

    // Hold the result word until taken; reload only when the slot frees
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && in_valid) |=> state_reg == ST_EXEC)
        else $error("accepted word not executed next cycle");

    a_scan_commit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && st.scan_done) |=> state_reg == ST_COMMIT)
        else $error("finished scan not committed");

    a_result_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RESULT && out_free) |=> (out_valid_reg && state_reg == ST_IDLE))
        else $error("result word not presented");

endmodule

`default_nettype wire

>>> rtl/ftn_datapath.sv
// Datapath of the focus tab-order navigator: tab table memory, hover and
// selection state, nearest/wrap scan unit and result register. Uses ftn_pkg.
`default_nettype none

module ftn_datapath #(
    parameter int MAX_ELEMENTS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ftn_pkg::ftn_cmd_t    cmd,
    input  ftn_pkg::ftn_item_t   item,
    output ftn_pkg::ftn_status_t st,
    output ftn_pkg::ftn_result_t result
);
    import ftn_pkg::*;

    localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int CW = $clog2(MAX_ELEMENTS + 1);
    localparam logic [CW-1:0] COUNT_FULL = CW'(MAX_ELEMENTS);

    logic [7:0] tab_mem [0:MAX_ELEMENTS-1];
    logic [7:0] rd_data_reg;

    ftn_item_t   item_reg;
    ftn_result_t result_reg;
    ftn_result_t result_next;

    logic [CW-1:0]     count_reg, count_next;
    logic              hover_present_reg, hover_present_next;
    logic [AW-1:0]     hover_idx_reg, hover_idx_next;
    logic [7:0]        hover_tab_reg, hover_tab_next;
    logic              sel_reg, sel_next;
    logic              dispatch_reg, dispatch_next;
    logic              rejected_reg, rejected_next;
    logic              up_reg, up_next;
    logic signed [8:0] prev_reg, prev_next;
    logic [CW-1:0]     ptr_reg, ptr_next;
    logic              chk_valid_reg, chk_valid_next;
    logic [AW-1:0]     chk_idx_reg, chk_idx_next;
    logic              near_found_reg, near_found_next;
    logic [7:0]        near_diff_reg, near_diff_next;
    logic [AW-1:0]     near_idx_reg, near_idx_next;
    logic [7:0]        near_val_reg, near_val_next;
    logic              wrap_found_reg, wrap_found_next;
    logic [AW-1:0]     wrap_idx_reg, wrap_idx_next;
    logic [7:0]        wrap_val_reg, wrap_val_next;

    logic              wr_en;
    logic              issue;
    logic              is_move;
    logic              is_cand;
    logic              beyond;
    logic              wrap_better;
    logic signed [8:0] t9;
    logic signed [8:0] wv9;
    logic signed [9:0] t10;
    logic signed [9:0] p10;
    logic signed [9:0] diff10;
    logic [7:0]        d8;
    logic [AW+3:0]     slot_ext;

    // Table memory: one write port (append), one registered read port (scan)
    always_ff @(posedge clk)
    begin
        if (wr_en)
            tab_mem[count_reg[AW-1:0]] <= item_reg.elem_tab;
        rd_data_reg <= tab_mem[ptr_reg[AW-1:0]];
    end

    assign issue   = ptr_reg < count_reg;
    assign is_move = item_reg.mode == MODE_KEY
                     && (item_reg.press_kind == PRESS_UP || item_reg.press_kind == PRESS_DOWN)
                     && !(hover_present_reg && sel_reg);
    assign wr_en   = cmd.exec && item_reg.mode == MODE_ADD && count_reg < COUNT_FULL;

    assign st.move_req  = is_move;
    assign st.scan_done = !issue && !chk_valid_reg;

    // Candidate evaluation on the word read last cycle
    assign t9      = {rd_data_reg[7], rd_data_reg};
    assign wv9     = {wrap_val_reg[7], wrap_val_reg};
    assign t10     = {{2{rd_data_reg[7]}}, rd_data_reg};
    assign p10     = {prev_reg[8], prev_reg};
    assign diff10  = up_reg ? (t10 - p10) : (p10 - t10);
    assign d8      = diff10[7:0];
    assign is_cand = rd_data_reg != TAB_NONE;
    assign beyond  = up_reg ? (t9 > prev_reg) : (t9 < prev_reg);
    assign wrap_better = !wrap_found_reg || (up_reg ? (t9 < wv9) : (t9 > wv9));

    always_comb
    begin
        count_next         = count_reg;
        hover_present_next = hover_present_reg;
        hover_idx_next     = hover_idx_reg;
        hover_tab_next     = hover_tab_reg;
        sel_next           = sel_reg;
        dispatch_next      = dispatch_reg;
        rejected_next      = rejected_reg;
        up_next            = up_reg;
        prev_next          = prev_reg;
        ptr_next           = ptr_reg;
        chk_valid_next     = chk_valid_reg;
        chk_idx_next       = chk_idx_reg;
        near_found_next    = near_found_reg;
        near_diff_next     = near_diff_reg;
        near_idx_next      = near_idx_reg;
        near_val_next      = near_val_reg;
        wrap_found_next    = wrap_found_reg;
        wrap_idx_next      = wrap_idx_reg;
        wrap_val_next      = wrap_val_reg;

        if (cmd.exec)
        begin
            dispatch_next = 1'b0;
            rejected_next = 1'b0;
            case (item_reg.mode)
                MODE_CLEAR:
                begin
                    count_next         = '0;
                    hover_present_next = 1'b0;
                    hover_idx_next     = '0;
                    sel_next           = 1'b0;
                end
                MODE_ADD:
                begin
                    if (count_reg < COUNT_FULL)
                        count_next = count_reg + CW'(1);
                    else
                        rejected_next = 1'b1;
                end
                MODE_SELECT:
                    sel_next = item_reg.toggle_flag ? !sel_reg : item_reg.select_value;
                MODE_KEY:
                begin
                    if (item_reg.press_kind == PRESS_UP || item_reg.press_kind == PRESS_DOWN)
                        dispatch_next = hover_present_reg && sel_reg;
                    else
                        dispatch_next = hover_present_reg;
                end
                default:
                    dispatch_next = 1'b0;
            endcase

            // Arm the scan from the current hover
            if (is_move)
            begin
                up_next = item_reg.press_kind == PRESS_UP;
                if (hover_present_reg)
                    prev_next = {hover_tab_reg[7], hover_tab_reg};
                else
                    prev_next = (item_reg.press_kind == PRESS_UP) ? PREV_UP_NONE
                                                                  : PREV_DOWN_NONE;
                ptr_next        = '0;
                chk_valid_next  = 1'b0;
                near_found_next = 1'b0;
                near_diff_next  = DIFF_NONE;
                wrap_found_next = 1'b0;
            end
        end

        if (cmd.scan_step)
        begin
            chk_valid_next = issue;
            chk_idx_next   = ptr_reg[AW-1:0];
            if (issue)
                ptr_next = ptr_reg + CW'(1);
            if (chk_valid_reg && is_cand)
            begin
                if (beyond && d8 < near_diff_reg)
                begin
                    near_found_next = 1'b1;
                    near_diff_next  = d8;
                    near_idx_next   = chk_idx_reg;
                    near_val_next   = rd_data_reg;
                end
                if (wrap_better)
                begin
                    wrap_found_next = 1'b1;
                    wrap_idx_next   = chk_idx_reg;
                    wrap_val_next   = rd_data_reg;
                end
            end
        end

        if (cmd.commit)
        begin
            hover_present_next = near_found_reg || wrap_found_reg;
            if (near_found_reg)
            begin
                hover_idx_next = near_idx_reg;
                hover_tab_next = near_val_reg;
            end
            else if (wrap_found_reg)
            begin
                hover_idx_next = wrap_idx_reg;
                hover_tab_next = wrap_val_reg;
            end
            else
                hover_idx_next = '0;
        end
    end

    assign slot_ext = {4'b0000, hover_idx_reg};

    always_comb
    begin
        result_next              = result_reg;
        if (cmd.load_out)
        begin
            result_next.hover_valid  = hover_present_reg;
            result_next.hover_slot   = hover_present_reg ? slot_ext[3:0] : 4'd0;
            result_next.dispatch     = dispatch_reg;
            result_next.selected     = sel_reg;
            result_next.add_rejected = rejected_reg;
        end
    end

    assign result = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg         <= '0;
            hover_present_reg <= 1'b0;
            hover_idx_reg     <= '0;
            sel_reg           <= 1'b0;
            ptr_reg           <= '0;
            chk_valid_reg     <= 1'b0;
            near_found_reg    <= 1'b0;
            wrap_found_reg    <= 1'b0;
        end
        else
        begin
            count_reg         <= count_next;
            hover_present_reg <= hover_present_next;
            hover_idx_reg     <= hover_idx_next;
            sel_reg           <= sel_next;
            ptr_reg           <= ptr_next;
            chk_valid_reg     <= chk_valid_next;
            near_found_reg    <= near_found_next;
            wrap_found_reg    <= wrap_found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            item_reg <= item;
        result_reg    <= result_next;
        hover_tab_reg <= hover_tab_next;
        dispatch_reg  <= dispatch_next;
        rejected_reg  <= rejected_next;
        up_reg        <= up_next;
        prev_reg      <= prev_next;
        chk_idx_reg   <= chk_idx_next;
        near_diff_reg <= near_diff_next;
        near_idx_reg  <= near_idx_next;
        near_val_reg  <= near_val_next;
        wrap_idx_reg  <= wrap_idx_next;
        wrap_val_reg  <= wrap_val_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_FULL)
        else $error("entry count beyond table depth");

    a_hover_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        hover_present_reg |-> CW'(hover_idx_reg) < count_reg)
        else $error("hover points past the filled table");

    a_full_reject: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && item_reg.mode == MODE_ADD && count_reg == COUNT_FULL)
        |=> (rejected_reg && count_reg == COUNT_FULL))
        else $error("add on full table not rejected");

endmodule

`default_nettype wire

>>> rtl/focus_tab_order_navigator.sv
// Top level of the focus tab-order navigator: joins controller and datapath
// to the command and result channels. Uses ftn_pkg, ftn_ifs, ftn_ctrl, ftn_datapath.
//
// One command word in, one result word out. Clear, add and select words,
// and key presses that do not move focus, pass from acceptance through the
// execute and result states. An up or down press that moves focus scans the
// filled part of the tab table through the table memory's single read port,
// one entry per cycle, tracking the nearest candidate and the wrap candidate
// together, then commits the new hover before its result. The next word is
// taken as soon as the previous one is done, while its result may still wait
// in the output register. Table contents are undefined after reset and are
// never cleared; only entries below the fill count are ever used by the scan.
`default_nettype none

module focus_tab_order_navigator #(
    parameter int MAX_ELEMENTS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    ftn_req_if.sink      req,
    ftn_rsp_if.source    rsp
);
    import ftn_pkg::*;

    ftn_cmd_t    cmd;
    ftn_status_t st;
    ftn_item_t   item;
    ftn_result_t result;

    // Pack the command word fields into the item struct
    assign item.mode         = ftn_mode_t'(req.mode);
    assign item.elem_tab     = req.elem_tab;
    assign item.press_kind   = ftn_press_t'(req.press_kind);
    assign item.toggle_flag  = req.toggle_flag;
    assign item.select_value = req.select_value;

    ftn_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .st        (st),
        .cmd       (cmd)
    );

    ftn_datapath #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .item   (item),
        .st     (st),
        .result (result)
    );

    // Drive the result word from the datapath's output register
    assign rsp.hover_valid  = result.hover_valid;
    assign rsp.hover_slot   = result.hover_slot;
    assign rsp.dispatch     = result.dispatch;
    assign rsp.selected     = result.selected;
    assign rsp.add_rejected = result.add_rejected;

endmodule

`default_nettype wire
